[rtl/ism_pkg.sv]
`default_nettype none

package ism_pkg;

   // Lattice geometry
   localparam int SIDE   = 8;
   localparam int SITES  = SIDE * SIDE;
   localparam int SITE_W = (SITES > 1) ? $clog2(SITES) : 1;

   // Field widths of the channels
   localparam int SITE_INDEX_W = 6;
   localparam int RANDOM_W     = 32;
   localparam int DE_W         = 5;
   localparam int MAG_OUT_W    = 8;
   localparam int BOND_OUT_W   = 9;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   // Site compare width: holds every site index, the input index and SITES itself
   localparam int ADDR_W = ((SITE_W > SITE_INDEX_W) ? SITE_W : SITE_INDEX_W) + 1;

   // Exact running sums, never narrower than the result fields
   localparam int MAG_EXACT_W  = $clog2(SITES + 1) + 1;
   localparam int BOND_EXACT_W = $clog2(2 * SITES + 1) + 1;
   localparam int MAG_W  = (MAG_EXACT_W > MAG_OUT_W) ? MAG_EXACT_W : MAG_OUT_W;
   localparam int BOND_W = (BOND_EXACT_W > BOND_OUT_W) ? BOND_EXACT_W : BOND_OUT_W;

   // Energy rises that need a random draw
   localparam logic signed [DE_W-1:0] DE_SMALL = 5'sd4;
   localparam logic signed [DE_W-1:0] DE_LARGE = 5'sd8;

   // Register select, taken from csr_paddr[2]
   typedef enum logic {
      REG_THRESHOLD_SMALL = 1'b0,
      REG_THRESHOLD_LARGE = 1'b1
   } ism_reg_type;

   // Update command to the lattice
   typedef struct packed {
      logic              clear;
      logic              flip;
      logic [ADDR_W-1:0] site;
   } ism_lat_cmd_type;

   // What the lattice shows for the queried site
   typedef struct packed {
      logic       self_down;
      logic [2:0] down_count;
   } ism_lat_view_type;

   // Energy change of an up spin with the given number of down neighbors
   function automatic logic signed [DE_W-1:0] de_for_up(input logic [2:0] down_count);
      logic signed [DE_W-1:0] de;
      case (down_count)
         3'd0:    de = 5'sd8;
         3'd1:    de = 5'sd4;
         3'd2:    de = 5'sd0;
         3'd3:    de = -5'sd4;
         default: de = -5'sd8;
      endcase
      return de;
   endfunction

endpackage

`default_nettype wire

[rtl/ism_lattice.sv]
`default_nettype none

module ism_lattice (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [ism_pkg::ADDR_W-1:0]    query_site,
   input  wire ism_pkg::ism_lat_cmd_type      cmd,
   output ism_pkg::ism_lat_view_type          view
);
   import ism_pkg::*;

   // One bit per site, 1 = spin down
   logic [SITES-1:0] down_ff;
   logic [SITES-1:0] down_in;
   logic [2:0]       nbr_count [SITES];

   // Count down neighbors of each site on the wrapped lattice
   for (genvar g = 0; g < SITES; g++) begin : g_site
      localparam int ROW = g / SIDE;
      localparam int COL = g % SIDE;
      localparam int NB_N = ((ROW + SIDE - 1) % SIDE) * SIDE + COL;
      localparam int NB_S = ((ROW + 1) % SIDE) * SIDE + COL;
      localparam int NB_W = ROW * SIDE + (COL + SIDE - 1) % SIDE;
      localparam int NB_E = ROW * SIDE + (COL + 1) % SIDE;
      assign nbr_count[g] = {2'b00, down_ff[NB_N]} + {2'b00, down_ff[NB_S]}
                          + {2'b00, down_ff[NB_W]} + {2'b00, down_ff[NB_E]};
   end

   // Select the queried site
   always_comb begin
      view = '0;
      for (int i = 0; i < SITES; i++) begin
         if (query_site == ADDR_W'(i)) begin
            view.self_down  = down_ff[i];
            view.down_count = nbr_count[i];
         end
      end
   end

   // Flip one site or set all up
   always_comb begin
      down_in = down_ff;
      for (int i = 0; i < SITES; i++) begin
         if (cmd.clear) begin
            down_in[i] = 1'b0;
         end else if (cmd.flip && cmd.site == ADDR_W'(i)) begin
            down_in[i] = ~down_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         down_ff <= '0;
      end else begin
         down_ff <= down_in;
      end
   end

endmodule

`default_nettype wire

[rtl/ising_metropolis_step.sv]
`default_nettype none

// Channel   Dir  Ports                         Beat contents
// req       in   req_tvalid/tready/tdata/tuser one trial or an all-up command
// rsp       out  rsp_tvalid/tready/tdata       one result per request beat
// csr       in   csr_p*                        acceptance thresholds at 0x0, 0x4
//
// Each request passes through the input register, where the neighbor lookup,
// acceptance test and lattice update run, and then through the result register.
// A new request is taken every cycle unless a stalled result holds the input register.
// Synchronous reset sets all spins up, the sums to their all-up values and the
// thresholds to zero. A stalled result holds the pipeline; the input register
// still drains into the result register as soon as it is taken.

module ising_metropolis_step (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request: tdata = site_index[5:0], random_word[37:6], zero pad [39:38]
   //          tuser = mode
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [39:0]                        req_tdata,
   input  wire logic                               req_tuser,
   // result: tdata = flip_accepted[0], energy_change[5:1],
   //         magnetization_sum[13:6], bond_sum[22:14], zero pad [23]
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [23:0]                             rsp_tdata,
   // configuration
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [ism_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [ism_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [ism_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                    csr_pready
);
   import ism_pkg::*;

   // Thresholds
   logic [RANDOM_W-1:0] thr_small_ff;
   logic [RANDOM_W-1:0] thr_large_ff;
   ism_reg_type         csr_sel;

   // Input register
   logic                    in_valid_ff;
   logic                    in_valid_in;
   logic                    in_mode_ff;
   logic [SITE_INDEX_W-1:0] in_site_ff;
   logic [RANDOM_W-1:0]     in_rnd_ff;

   // Running sums
   logic signed [MAG_W-1:0]  mag_ff;
   logic signed [MAG_W-1:0]  mag_in;
   logic signed [BOND_W-1:0] bond_ff;
   logic signed [BOND_W-1:0] bond_in;

   // Result register
   logic                         out_valid_ff;
   logic                         out_valid_in;
   logic                         out_flip_ff;
   logic signed [DE_W-1:0]       out_de_ff;
   logic signed [MAG_OUT_W-1:0]  out_mag_ff;
   logic signed [BOND_OUT_W-1:0] out_bond_ff;

   // Datapath
   logic                   req_beat;
   logic                   advance;
   logic [ADDR_W-1:0]      site_ext;
   logic                   in_range;
   logic                   trial;
   logic signed [DE_W-1:0] de_up;
   logic signed [DE_W-1:0] de;
   logic                   flip;
   ism_lat_cmd_type        lat_cmd;
   ism_lat_view_type       lat_view;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_sel    = ism_reg_type'(csr_paddr[2]);

   always_comb begin
      unique case (csr_sel)
         REG_THRESHOLD_SMALL: csr_prdata = thr_small_ff;
         REG_THRESHOLD_LARGE: csr_prdata = thr_large_ff;
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_small_ff <= '0;
         thr_large_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         unique case (csr_sel)
            REG_THRESHOLD_SMALL: thr_small_ff <= csr_pwdata;
            REG_THRESHOLD_LARGE: thr_large_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // Handshake: advance when the result register is free or being drained
   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign req_beat    = req_tvalid && req_tready;
   assign in_valid_in = req_beat ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Capture the request beat
   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_mode_ff <= req_tuser;
         in_site_ff <= req_tdata[SITE_INDEX_W-1:0];
         in_rnd_ff  <= req_tdata[SITE_INDEX_W+RANDOM_W-1:SITE_INDEX_W];
      end
   end

   // Lattice lookup and update
   assign site_ext = ADDR_W'(in_site_ff);
   assign in_range = site_ext < ADDR_W'(SITES);
   assign trial    = !in_mode_ff && in_range;

   assign lat_cmd.clear = advance && in_mode_ff;
   assign lat_cmd.flip  = advance && flip;
   assign lat_cmd.site  = site_ext;

   ism_lattice u_lattice (
      .clock      (clock),
      .reset      (reset),
      .query_site (site_ext),
      .cmd        (lat_cmd),
      .view       (lat_view)
   );

   // Energy change and acceptance test
   assign de_up = de_for_up(lat_view.down_count);

   always_comb begin
      if (!trial) begin
         de = '0;
      end else if (lat_view.self_down) begin
         de = -de_up;
      end else begin
         de = de_up;
      end
   end

   always_comb begin
      if (!trial) begin
         flip = 1'b0;
      end else if (de[DE_W-1] || de == '0) begin
         flip = 1'b1;
      end else if (de == DE_SMALL) begin
         flip = in_rnd_ff <= thr_small_ff;
      end else begin
         flip = in_rnd_ff <= thr_large_ff;
      end
   end

   // Next running sums
   always_comb begin
      mag_in  = mag_ff;
      bond_in = bond_ff;
      if (in_mode_ff) begin
         mag_in  = MAG_W'(SITES);
         bond_in = BOND_W'(2 * SITES);
      end else if (flip) begin
         mag_in  = lat_view.self_down ? mag_ff + MAG_W'(2) : mag_ff - MAG_W'(2);
         bond_in = bond_ff - BOND_W'(de);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_ff  <= MAG_W'(SITES);
         bond_ff <= BOND_W'(2 * SITES);
      end else if (advance) begin
         mag_ff  <= mag_in;
         bond_ff <= bond_in;
      end
   end

   // Result register
   assign out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_flip_ff <= flip;
         out_de_ff   <= de;
         out_mag_ff  <= mag_in[MAG_OUT_W-1:0];
         out_bond_ff <= bond_in[BOND_OUT_W-1:0];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_bond_ff, out_mag_ff, out_de_ff, out_flip_ff};

endmodule

`default_nettype wire

[rtl/ism_checker.sv]
`default_nettype none

module ism_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata
);
   import ism_pkg::*;

   // Result field positions
   localparam int DE_LSB   = 1;
   localparam int MAG_LSB  = DE_LSB + DE_W;
   localparam int BOND_LSB = MAG_LSB + MAG_OUT_W;

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Energy change is a multiple of four, magnetization even, bonds a multiple of four
   a_sum_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[DE_LSB+1:DE_LSB] == 2'b00 && rsp_tdata[MAG_LSB] == 1'b0
                     && rsp_tdata[BOND_LSB+1:BOND_LSB] == 2'b00)
      else $error("result sums off their lattice");

   // An energy drop is always taken
   a_drop_flips: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[DE_LSB+DE_W-1] |-> rsp_tdata[0])
      else $error("energy drop not flipped");

   // Stall the request side only behind a blocked result
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request stalled with the result side free");

endmodule

bind ising_metropolis_step ism_checker u_ism_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

[tb/ising_metropolis_step_test.sv]
`default_nettype none

module ising_metropolis_step_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ism_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   // One request beat as the sender sees it
   typedef struct {
      logic                    mode;
      logic [SITE_INDEX_W-1:0] site;
      logic [RANDOM_W-1:0]     rnd;
   } trial_type;

   // One result beat, split into its fields
   typedef struct {
      logic                         flip;
      logic signed [DE_W-1:0]       de;
      logic signed [MAG_OUT_W-1:0]  mag;
      logic signed [BOND_OUT_W-1:0] bonds;
   } outcome_type;

   logic        clock;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // site_index[5:0], random_word[37:6], pad[39:38]
   logic        req_tuser  = 1'b0; // mode

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // flip[0], dE[5:1], magnetization[13:6], bonds[22:14]

   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Lattice mirror and acceptance levels
   bit          spin_down [SITES];
   int          magnet_total;
   int          bond_total;
   logic [31:0] accept_small_level;
   logic [31:0] accept_large_level;

   trial_type   pending_trials[$];
   outcome_type expected_results[$];
   outcome_type want;
   outcome_type got;
   int          idle_pct = 13;
   int          mismatches = 0;
   int          result_count = 0;
   int          cycle_count = 0;
   logic [31:0] level_pick;

   ising_metropolis_step u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void lattice_all_up();
      foreach (spin_down[i]) spin_down[i] = 1'b0;
      magnet_total = SITES;
      bond_total   = 2 * SITES;
   endfunction

   function automatic int spin_of(int row, int col);
      return spin_down[row * SIDE + col] ? -1 : 1;
   endfunction

   // Apply one trial to the mirror and return the result it must produce
   function automatic outcome_type metropolis_predict(trial_type t);
      outcome_type o;
      int row, col, s, h, de;
      bit flip;
      de   = 0;
      flip = 1'b0;
      if (t.mode) begin
         lattice_all_up();
      end else if (int'(t.site) < SITES) begin
         row = t.site / SIDE;
         col = t.site % SIDE;
         s = spin_of(row, col);
         h = spin_of((row + 1) % SIDE, col) + spin_of((row + SIDE - 1) % SIDE, col)
           + spin_of(row, (col + 1) % SIDE) + spin_of(row, (col + SIDE - 1) % SIDE);
         de = 2 * s * h;
         if (de <= 0)
            flip = 1'b1;
         else if (de == int'(DE_SMALL))
            flip = (t.rnd <= accept_small_level);
         else
            flip = (t.rnd <= accept_large_level);
         if (flip) begin
            spin_down[t.site] = ~spin_down[t.site];
            magnet_total -= 2 * s;
            bond_total   -= de;
         end
      end
      o.flip  = flip;
      o.de    = de[DE_W-1:0];
      o.mag   = magnet_total[MAG_OUT_W-1:0];
      o.bonds = bond_total[BOND_OUT_W-1:0];
      return o;
   endfunction

   // Mostly trials; random words lean on the extremes and the threshold edges
   function automatic trial_type random_trial();
      trial_type t;
      t.mode = ($urandom_range(0, 99) < 3);
      t.site = SITE_INDEX_W'($urandom_range(0, 63));
      case ($urandom_range(0, 9))
         0:       t.rnd = '0;
         1:       t.rnd = '1;
         2:       t.rnd = accept_small_level + $urandom_range(0, 2) - 1;
         3:       t.rnd = accept_large_level + $urandom_range(0, 2) - 1;
         default: t.rnd = $urandom;
      endcase
      return t;
   endfunction

   function automatic void add_trial(logic mode, logic [5:0] site, logic [31:0] rnd);
      trial_type t;
      t.mode = mode;
      t.site = site;
      t.rnd  = rnd;
      pending_trials.push_back(t);
   endfunction

   task automatic csr_write(input ism_reg_type which, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {which, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (which == REG_THRESHOLD_SMALL)
         accept_small_level = value;
      else
         accept_large_level = value;
   endtask

   // Hold off until every queued beat has gone out and come back
   task automatic wait_idle();
      while (pending_trials.size() != 0 || expected_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(input logic [31:0] small_lvl, input logic [31:0] large_lvl,
                            input int count, input int idle);
      wait_idle();
      csr_write(REG_THRESHOLD_SMALL, small_lvl);
      csr_write(REG_THRESHOLD_LARGE, large_lvl);
      idle_pct <= idle;
      @(negedge clock);
      repeat (count) pending_trials.push_back(random_trial());
   endtask

   // Request driver: hold a stalled beat, else offer the next one or idle
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_results.push_back(metropolis_predict(pending_trials.pop_front()));
         if (req_tvalid && !req_tready) begin
            // keep the beat on the bus
         end else if (pending_trials.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            req_tvalid <= 1'b1;
            req_tuser  <= pending_trials[0].mode;
            req_tdata  <= {2'b00, pending_trials[0].rnd, pending_trials[0].site};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result monitor: compare each beat with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            got.flip  = rsp_tdata[0];
            got.de    = rsp_tdata[5:1];
            got.mag   = rsp_tdata[13:6];
            got.bonds = rsp_tdata[22:14];
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: unexpected beat tdata=%h", result_count, rsp_tdata);
            end else begin
               want = expected_results.pop_front();
               if (got.flip !== want.flip || got.de !== want.de ||
                   got.mag !== want.mag || got.bonds !== want.bonds) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result %0d: expected flip=%0d dE=%0d mag=%0d bonds=%0d",
                              result_count, want.flip, want.de, want.mag, want.bonds,
                              ", got flip=%0d dE=%0d mag=%0d bonds=%0d",
                              got.flip, got.de, got.mag, got.bonds);
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= idle_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      lattice_all_up();
      accept_small_level = '0;
      accept_large_level = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed walk at reset thresholds: every dE, both extremes, wraps, all-up command
      add_trial(1'b1, 6'h3F, 32'hFFFF_FFFF);
      add_trial(1'b0, 6'd0,  32'hFFFF_FFFF);  // dE 8 rejected
      add_trial(1'b0, 6'd0,  32'h0);          // dE 8 taken on an equal draw
      add_trial(1'b0, 6'd0,  32'h0);          // dE -8
      add_trial(1'b0, 6'd9,  32'h0);
      add_trial(1'b0, 6'd1,  32'h0);          // dE 4 taken
      add_trial(1'b0, 6'd1,  32'h0);          // dE -4
      add_trial(1'b0, 6'd10, 32'h1);          // dE 4 rejected by one
      add_trial(1'b0, 6'd0,  32'h0);
      add_trial(1'b0, 6'd1,  32'h5A5A_5A5A);  // dE 0
      add_trial(1'b0, 6'd63, 32'h0);
      add_trial(1'b0, 6'd7,  32'h0);
      add_trial(1'b0, 6'd56, 32'h0);
      add_trial(1'b0, 6'd63, 32'hA5A5_A5A5);  // corner with wrapped neighbors
      add_trial(1'b1, 6'd0,  32'h0);
      add_trial(1'b0, 6'd36, 32'hAAAA_AAAA);
      add_trial(1'b0, 6'd27, 32'h5555_5555);
      add_trial(1'b0, 6'h2A, 32'h0);

      // Random phases over a spread of thresholds, extremes included
      run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 180, 13);
      run_phase($urandom, $urandom, 180, 13);
      run_phase(32'h8000_0000, 32'h0, 180, 0);
      run_phase(32'h0, 32'hFFFF_FFFF, 180, 13);
      level_pick = $urandom;
      run_phase(level_pick, $urandom_range(0, level_pick), 180, 13);
      run_phase(32'hFFFF_FFFF, 32'h0, 180, 13);

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
